// ===== src/sha1_byte_stream_hasher_defines.svh =====
// Assertion macros shared by the SHA-1 byte stream hasher.
`ifndef SHA1_BYTE_STREAM_HASHER_DEFINES_SVH
`define SHA1_BYTE_STREAM_HASHER_DEFINES_SVH

// The condition must hold in the same cycle as the trigger.
`define SBH_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sha1bsh: same-cycle check failed");

// The condition must hold in the cycle after the trigger.
`define SBH_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sha1bsh: next-cycle check failed");

`endif

// ===== src/sha1bsh_pkg.sv =====
// Types and constants shared by the SHA-1 byte stream hasher modules.
`default_nettype none
package sha1bsh_pkg;

	localparam int unsigned ROUNDS   = 80;
	localparam int unsigned RND_W    = 7;
	localparam int unsigned FILL_W   = 6;
	localparam int unsigned LCNT_W   = 3;
	localparam int unsigned BLK_BITS = 512;

	localparam logic [FILL_W-1:0] FILL_LAST   = 6'd63;
	localparam logic [FILL_W-1:0] FILL_LENPOS = 6'd56;
	localparam logic [LCNT_W-1:0] LCNT_LAST   = 3'd7;
	localparam logic [RND_W-1:0]  RND_LAST    = 7'(ROUNDS - 1);
	localparam logic [63:0]       LEN_WRAP    = 64'hFFFF_FFFF_FFFF_FFF8;
	localparam logic [7:0]        PAD_BYTE    = 8'h80;

	localparam logic [31:0] INIT_H [5] = '{
		32'h6745_2301, 32'hEFCD_AB89, 32'h98BA_DCFE, 32'h1032_5476, 32'hC3D2_E1F0
	};
	localparam logic [31:0] ROUND_K [4] = '{
		32'h5A82_7999, 32'h6ED9_EBA1, 32'h8F1B_BCDC, 32'hCA62_C1D6
	};

	typedef enum logic [1:0] {
		CMD_APPEND  = 2'd0,
		CMD_FINISH  = 2'd1,
		CMD_RESTART = 2'd2
	} req_cmd_t;

	typedef enum logic [1:0] {
		SEL_DATA,
		SEL_PAD,
		SEL_ZERO,
		SEL_LEN
	} byte_sel_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD_ONE,
		ST_PAD_ZERO,
		ST_PAD_LEN,
		ST_ROUND,
		ST_FINAL,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic      shift_en;
		byte_sel_t byte_sel;
		logic      count_len;
		logic      round_en;
		logic      final_en;
		logic      restart;
		logic      out_load;
		logic      out_zero;
	} ctrl_cmd_t;

	typedef struct packed {
		logic fill_last;
		logic fill_at_len;
		logic len_last;
		logic round_last;
		logic len_wrap;
		logic out_free;
	} dp_stat_t;

endpackage
`default_nettype wire

// ===== src/sha1bsh_datapath.sv =====
// Datapath: block shift register, length counter, round logic, chaining words and result register.
`default_nettype none
module sha1bsh_datapath (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [7:0]            data_byte,
	input  sha1bsh_pkg::ctrl_cmd_t     ctl,
	output sha1bsh_pkg::dp_stat_t      stat,
	input  wire logic                  rsp_stall,
	output logic                       rsp_valid,
	output logic [31:0]                digest_word0,
	output logic [31:0]                digest_word1,
	output logic [31:0]                digest_word2,
	output logic [31:0]                digest_word3,
	output logic [31:0]                digest_word4,
	output logic                       ok
);
	import sha1bsh_pkg::*;

	logic [BLK_BITS-1:0] blk_q;
	logic [FILL_W-1:0]   fill_q;
	logic [63:0]         len_q;
	logic [LCNT_W-1:0]   lcnt_q;
	logic [RND_W-1:0]    rnd_q;
	logic [31:0]         h_q [5];
	logic [31:0]         v_q [5];
	logic [31:0]         dig_q [5];
	logic                ok_q;
	logic                rsp_valid_q;

	logic [7:0]  in_byte;
	logic [7:0]  len_byte;
	logic [31:0] w_new;
	logic [31:0] f_val;
	logic [31:0] k_val;
	logic [31:0] t_val;
	logic [31:0] sum [5];

	assign len_byte = len_q[{~lcnt_q, 3'b000} +: 8];

	always_comb begin
		case (ctl.byte_sel)
			SEL_DATA: in_byte = data_byte;
			SEL_PAD:  in_byte = PAD_BYTE;
			SEL_ZERO: in_byte = 8'h00;
			SEL_LEN:  in_byte = len_byte;
			default:  in_byte = 8'h00;
		endcase
	end

	always_comb begin
		logic [31:0] x;
		x = blk_q[95:64] ^ blk_q[255:224] ^ blk_q[447:416] ^ blk_q[511:480];
		w_new = {x[30:0], x[31]};
	end

	always_comb begin
		if (rnd_q inside {[7'd0:7'd19]}) begin
			f_val = (v_q[1] & v_q[2]) | (~v_q[1] & v_q[3]);
			k_val = ROUND_K[0];
		end else if (rnd_q inside {[7'd20:7'd39]}) begin
			f_val = v_q[1] ^ v_q[2] ^ v_q[3];
			k_val = ROUND_K[1];
		end else if (rnd_q inside {[7'd40:7'd59]}) begin
			f_val = (v_q[1] & v_q[2]) | (v_q[1] & v_q[3]) | (v_q[2] & v_q[3]);
			k_val = ROUND_K[2];
		end else begin
			f_val = v_q[1] ^ v_q[2] ^ v_q[3];
			k_val = ROUND_K[3];
		end
		t_val = {v_q[0][26:0], v_q[0][31:27]} + f_val + v_q[4] + blk_q[511:480] + k_val;
	end

	always_comb begin
		for (int i = 0; i < 5; i++) begin
			sum[i] = h_q[i] + v_q[i];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift_en) begin
			blk_q <= {blk_q[BLK_BITS-9:0], in_byte};
		end else if (ctl.round_en) begin
			blk_q <= {blk_q[BLK_BITS-33:0], w_new};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			len_q  <= '0;
			lcnt_q <= '0;
			rnd_q  <= '0;
			for (int i = 0; i < 5; i++) begin
				h_q[i] <= INIT_H[i];
				v_q[i] <= INIT_H[i];
			end
		end else if (ctl.restart) begin
			fill_q <= '0;
			len_q  <= '0;
			lcnt_q <= '0;
			rnd_q  <= '0;
			for (int i = 0; i < 5; i++) begin
				h_q[i] <= INIT_H[i];
				v_q[i] <= INIT_H[i];
			end
		end else begin
			if (ctl.shift_en) begin
				fill_q <= fill_q + 1'b1;
			end
			if (ctl.count_len) begin
				len_q <= len_q + 64'd8;
			end
			if (ctl.shift_en && ctl.byte_sel == SEL_LEN) begin
				lcnt_q <= lcnt_q + 1'b1;
			end
			if (ctl.round_en) begin
				rnd_q   <= (rnd_q == RND_LAST) ? '0 : rnd_q + 1'b1;
				v_q[0] <= t_val;
				v_q[1] <= v_q[0];
				v_q[2] <= {v_q[1][1:0], v_q[1][31:2]};
				v_q[3] <= v_q[2];
				v_q[4] <= v_q[3];
			end else if (ctl.final_en) begin
				for (int i = 0; i < 5; i++) begin
					h_q[i] <= sum[i];
					v_q[i] <= sum[i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			for (int i = 0; i < 5; i++) begin
				dig_q[i] <= ctl.out_zero ? 32'h0 : h_q[i];
			end
			ok_q <= ~ctl.out_zero;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign stat.fill_last   = (fill_q == FILL_LAST);
	assign stat.fill_at_len = (fill_q == FILL_LENPOS);
	assign stat.len_last    = (lcnt_q == LCNT_LAST);
	assign stat.round_last  = (rnd_q == RND_LAST);
	assign stat.len_wrap    = (len_q == LEN_WRAP);
	assign stat.out_free    = ~rsp_valid_q | ~rsp_stall;

	assign rsp_valid    = rsp_valid_q;
	assign digest_word0 = dig_q[0];
	assign digest_word1 = dig_q[1];
	assign digest_word2 = dig_q[2];
	assign digest_word3 = dig_q[3];
	assign digest_word4 = dig_q[4];
	assign ok           = ok_q;

endmodule
`default_nettype wire

// ===== src/sha1bsh_ctrl.sv =====
// Controller: state machine that sequences byte intake, padding, rounds and result delivery.
`default_nettype none
`include "sha1_byte_stream_hasher_defines.svh"
module sha1bsh_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_valid,
	input  wire logic [1:0]       cmd,
	output logic                  req_stall,
	input  sha1bsh_pkg::dp_stat_t stat,
	output sha1bsh_pkg::ctrl_cmd_t ctl
);
	import sha1bsh_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   done_q;
	logic   error_q;
	logic   finishing_q;
	logic   len_done_q;
	logic   accept;

	assign accept    = req_valid && (state_q == ST_IDLE);
	assign req_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (cmd == CMD_APPEND) begin
						if (!done_q && !error_q && stat.fill_last) begin
							state_d = ST_ROUND;
						end
					end else if (cmd == CMD_FINISH) begin
						state_d = (done_q || error_q) ? ST_EMIT : ST_PAD_ONE;
					end
				end
			end
			ST_PAD_ONE: begin
				state_d = stat.fill_last ? ST_ROUND : ST_PAD_ZERO;
			end
			ST_PAD_ZERO: begin
				if (stat.fill_at_len) begin
					state_d = ST_PAD_LEN;
				end else if (stat.fill_last) begin
					state_d = ST_ROUND;
				end
			end
			ST_PAD_LEN: begin
				if (stat.len_last) begin
					state_d = ST_ROUND;
				end
			end
			ST_ROUND: begin
				if (stat.round_last) begin
					state_d = ST_FINAL;
				end
			end
			ST_FINAL: begin
				if (len_done_q) begin
					state_d = ST_EMIT;
				end else if (finishing_q) begin
					state_d = ST_PAD_ZERO;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		ctl.byte_sel = SEL_DATA;
		case (state_q)
			ST_IDLE: begin
				if (accept && cmd == CMD_APPEND && !done_q && !error_q) begin
					ctl.shift_en  = 1'b1;
					ctl.count_len = 1'b1;
				end
				if (accept && cmd == CMD_RESTART) begin
					ctl.restart = 1'b1;
				end
			end
			ST_PAD_ONE: begin
				ctl.shift_en = 1'b1;
				ctl.byte_sel = SEL_PAD;
			end
			ST_PAD_ZERO: begin
				ctl.shift_en = ~stat.fill_at_len;
				ctl.byte_sel = SEL_ZERO;
			end
			ST_PAD_LEN: begin
				ctl.shift_en = 1'b1;
				ctl.byte_sel = SEL_LEN;
			end
			ST_ROUND: ctl.round_en = 1'b1;
			ST_FINAL: ctl.final_en = 1'b1;
			ST_EMIT: begin
				ctl.out_load = stat.out_free;
				ctl.out_zero = error_q;
			end
			default: ctl.byte_sel = SEL_DATA;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			done_q      <= 1'b0;
			error_q     <= 1'b0;
			finishing_q <= 1'b0;
			len_done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && cmd == CMD_RESTART) begin
				done_q      <= 1'b0;
				error_q     <= 1'b0;
				finishing_q <= 1'b0;
				len_done_q  <= 1'b0;
			end else if (accept && cmd == CMD_APPEND) begin
				if (done_q || error_q || stat.len_wrap) begin
					error_q <= 1'b1;
				end
			end else if (accept && cmd == CMD_FINISH && !done_q && !error_q) begin
				finishing_q <= 1'b1;
			end
			if (state_q == ST_PAD_LEN && stat.len_last) begin
				len_done_q <= 1'b1;
			end
			if (state_q == ST_FINAL && len_done_q) begin
				done_q      <= 1'b1;
				finishing_q <= 1'b0;
				len_done_q  <= 1'b0;
			end
		end
	end

	`SBH_ASSERT_NEXT(a_round_to_final, state_q == ST_ROUND && stat.round_last, state_q == ST_FINAL)
	`SBH_ASSERT_NEXT(a_byte_after_done, accept && cmd == CMD_APPEND && done_q, error_q)
	`SBH_ASSERT_NOW(a_len_block_end, state_q == ST_PAD_LEN && stat.len_last, stat.fill_last)
	`SBH_ASSERT_NEXT(a_finish_path, accept && cmd == CMD_FINISH,
		state_q == ST_EMIT || state_q == ST_PAD_ONE)

endmodule
`default_nettype wire

// ===== src/sha1_byte_stream_hasher.sv =====
// Top level of the SHA-1 byte stream hasher: controller and datapath.
// An append request shifts in one byte; when it completes a block, the 80 rounds and the chaining add follow.
// A finish request pads one byte per cycle up to the block end, holding once at the length position,
// and runs the rounds per block; when more than 55 bytes are pending, the padding spills into a second block.
// A repeated finish or a finish in error goes straight to result delivery; requests are one at a time.
// Reset clears control, loads the initial chaining words; the block buffer is undefined until filled.
`default_nettype none
module sha1_byte_stream_hasher (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire logic [1:0]  cmd,
	input  wire logic [7:0]  data_byte,
	output logic             rsp_valid,
	input  wire logic        rsp_stall,
	output logic [31:0]      digest_word0,
	output logic [31:0]      digest_word1,
	output logic [31:0]      digest_word2,
	output logic [31:0]      digest_word3,
	output logic [31:0]      digest_word4,
	output logic             ok
);
	import sha1bsh_pkg::*;

	ctrl_cmd_t ctl;
	dp_stat_t  stat;

	sha1bsh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.cmd       (cmd),
		.req_stall (req_stall),
		.stat      (stat),
		.ctl       (ctl)
	);

	sha1bsh_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.data_byte    (data_byte),
		.ctl          (ctl),
		.stat         (stat),
		.rsp_stall    (rsp_stall),
		.rsp_valid    (rsp_valid),
		.digest_word0 (digest_word0),
		.digest_word1 (digest_word1),
		.digest_word2 (digest_word2),
		.digest_word3 (digest_word3),
		.digest_word4 (digest_word4),
		.ok           (ok)
	);

endmodule
`default_nettype wire
